// ===== rtl/shared_exclusive_lock_table_unit_defines.svh =====
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_UNIT_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_UNIT_DEFINES_SVH

// Checks that a condition implies another condition in the same cycle.
`define SEL_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Checks that a condition implies another condition in the next cycle.
`define SEL_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/sel_pkg.sv =====
`default_nettype none
package sel_pkg;
    localparam int MODE_W  = 2;
    localparam int TXN_W   = 4;
    localparam int KEY_W   = 3;
    localparam int KIND_W  = 3;
    localparam int ENTRY_W = TXN_W + 1;

    localparam int DEF_NUM_KEYS    = 8;
    localparam int DEF_NUM_TXNS    = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_SHARED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXCL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REL_ALL = 2'd3;

    localparam logic [KIND_W-1:0] KIND_GRANTED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUED      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAITER_GRNT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_KEY = 3'd4;
    localparam logic [KIND_W-1:0] KIND_QUEUE_FULL  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ALL_RELEASE = 3'd6;
    localparam logic [KIND_W-1:0] KIND_BAD_TXN     = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TXN_W-1:0]  txn_out;
        logic [KEY_W-1:0]  key_out;
        logic              last;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/sel_req_if.sv =====
`default_nettype none
interface sel_req_if import sel_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TXN_W-1:0]  txn;
    logic [KEY_W-1:0]  key;

    modport source (output valid, mode, txn, key, input ready);
    modport sink (input valid, mode, txn, key, output ready);
endinterface
`default_nettype wire

// ===== rtl/sel_res_if.sv =====
`default_nettype none
interface sel_res_if import sel_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TXN_W-1:0]  txn_out;
    logic [KEY_W-1:0]  key_out;
    logic              last;

    modport source (output valid, kind, txn_out, key_out, last, input ready);
    modport sink (input valid, kind, txn_out, key_out, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/shared_exclusive_lock_table_unit.sv =====
// Shared/exclusive lock table. Each request item acquires a shared or exclusive
// lock on a key, releases one key, or releases every key a transaction holds;
// the block answers with one or more result items, the final one marked by
// last. Requests that cannot be granted wait in a per-key queue, kept in
// arrival order in a small RAM; a full queue rejects them. One item is
// handled at a time and the request side is not ready until the final
// result of the previous item has gone to the output register. A release
// walks the key's queue, reading each entry from the RAM and then comparing
// it; a release all steps through every key and walks the queue of each
// held key. Results stall the sequencer only while the output register is
// full.
`default_nettype none
`include "shared_exclusive_lock_table_unit_defines.svh"
module shared_exclusive_lock_table_unit import sel_pkg::*; #(
    parameter int NUM_KEYS    = DEF_NUM_KEYS,
    parameter int NUM_TXNS    = DEF_NUM_TXNS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sel_req_if.sink    i_req,
    sel_res_if.source  o_res
);
    localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int TXW   = $clog2(NUM_TXNS);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = NUM_KEYS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KCW   = $clog2(NUM_KEYS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_RA_STEP = 3'd2;
    localparam logic [2:0] ST_SCAN_RD = 3'd3;
    localparam logic [2:0] ST_SCAN_EV = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    logic [2:0]          r_state;
    logic [MODE_W-1:0]   r_mode;
    logic [TXN_W-1:0]    r_txn;
    logic [KEY_W-1:0]    r_key;
    logic [KW-1:0]       r_kidx;
    logic [TXN_W-1:0]    r_excl   [NUM_KEYS];
    logic [NUM_TXNS-1:0] r_shared [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_known;
    logic [CW-1:0]       r_wcnt   [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_held   [NUM_TXNS];
    logic [NUM_KEYS-1:0] r_snap;
    logic [KCW-1:0]      r_kcnt;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_kept;
    logic                r_stop;
    logic                r_from_ra;
    logic                r_pend_valid;
    t_res                r_pend;
    logic                r_out_valid;
    t_res                r_out;

    logic                txn_ok;
    logic                key_ok;
    logic [TXW-1:0]      tidx;
    logic [NUM_TXNS-1:0] tmask;
    logic [NUM_KEYS-1:0] kmask;
    logic [AW-1:0]       base;
    logic                out_free;
    logic                can_emit;
    logic [KW-1:0]       ra_k;
    logic [ENTRY_W-1:0]  rd_entry;
    logic [TXN_W-1:0]    e_txn;
    logic                e_excl;
    logic                e_grant;
    logic                acq_excl;
    logic                acq_ok;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;

    assign txn_ok   = (r_txn != '0) && (32'(r_txn) < NUM_TXNS);
    assign key_ok   = 32'(r_key) < NUM_KEYS;
    assign tidx     = TXW'(r_txn);
    assign tmask    = (NUM_TXNS)'(1) << tidx;
    assign kmask    = (NUM_KEYS)'(1) << r_kidx;
    assign base     = AW'(r_kidx * QUEUE_DEPTH);
    assign out_free = !r_out_valid || o_res.ready;
    assign can_emit = !r_pend_valid || out_free;
    assign ra_k     = KW'(r_kcnt);
    assign e_txn    = rd_entry[TXN_W-1:0];
    assign e_excl   = rd_entry[TXN_W];
    assign acq_excl = (r_mode == MODE_EXCL);

    always_comb begin
        e_grant = 1'b0;
        if (!r_stop && (32'(e_txn) < NUM_TXNS)) begin
            if (e_excl) begin
                e_grant = (r_excl[r_kidx] == '0) && (r_shared[r_kidx] == '0);
            end else begin
                e_grant = (r_excl[r_kidx] == '0);
            end
        end
        if (acq_excl) begin
            acq_ok = (r_excl[r_kidx] == '0) && (r_shared[r_kidx] == '0);
        end else begin
            acq_ok = (r_excl[r_kidx] == '0);
        end
    end

    // Queue RAM port control: new waiters are appended during decode, and the
    // scan compacts kept entries toward the head while reading ahead.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = base + AW'(r_kept);
        ram_wdata = rd_entry;
        ram_re    = 1'b0;
        ram_raddr = base + AW'(r_idx);
        case (r_state)
            ST_DECODE: begin
                if (txn_ok && r_mode != MODE_REL_ALL && r_mode != MODE_RELEASE && key_ok
                        && !acq_ok && (r_wcnt[r_kidx] < CW'(QUEUE_DEPTH))) begin
                    ram_we    = 1'b1;
                    ram_waddr = base + AW'(r_wcnt[r_kidx]);
                    ram_wdata = {acq_excl, r_txn};
                end
            end
            ST_SCAN_RD: begin
                ram_re = (r_idx < r_wcnt[r_kidx]);
            end
            ST_SCAN_EV: begin
                ram_we = !e_grant;
            end
            default: begin
            end
        endcase
    end

    sel_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.kind    = r_out.kind;
    assign o_res.txn_out = r_out.txn_out;
    assign o_res.key_out = r_out.key_out;
    assign o_res.last    = r_out.last;

    // Results pass through a one-deep pending slot so that the last flag can
    // be set once the sequencer knows no further result follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_kidx       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_known      <= '0;
            r_stop       <= 1'b0;
            r_from_ra    <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_excl[k]   <= '0;
                r_shared[k] <= '0;
                r_wcnt[k]   <= '0;
            end
            for (int t = 0; t < NUM_TXNS; t++) begin
                r_held[t] <= '0;
            end
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_mode  <= i_req.mode;
                        r_txn   <= i_req.txn;
                        r_key   <= i_req.key;
                        r_kidx  <= KW'(i_req.key);
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_pend_valid     <= 1'b1;
                    r_pend.txn_out   <= r_txn;
                    r_pend.key_out   <= r_key;
                    r_pend.last      <= 1'b0;
                    r_state          <= ST_FINISH;
                    if (!txn_ok) begin
                        r_pend.kind <= KIND_BAD_TXN;
                        if (r_mode == MODE_REL_ALL) begin
                            r_pend.key_out <= '0;
                        end
                    end else if (r_mode == MODE_REL_ALL) begin
                        r_pend_valid <= 1'b0;
                        r_snap       <= r_held[tidx];
                        r_kcnt       <= '0;
                        r_state      <= ST_RA_STEP;
                    end else if (!key_ok) begin
                        r_pend.kind <= KIND_UNKNOWN_KEY;
                    end else if (r_mode == MODE_RELEASE) begin
                        if (!r_known[r_kidx]) begin
                            r_pend.kind <= KIND_UNKNOWN_KEY;
                        end else begin
                            r_pend.kind      <= KIND_RELEASED;
                            r_shared[r_kidx] <= r_shared[r_kidx] & ~tmask;
                            if (r_excl[r_kidx] == r_txn) begin
                                r_excl[r_kidx] <= '0;
                            end
                            r_held[tidx] <= r_held[tidx] & ~kmask;
                            r_idx        <= '0;
                            r_kept       <= '0;
                            r_stop       <= 1'b0;
                            r_from_ra    <= 1'b0;
                            r_state      <= ST_SCAN_RD;
                        end
                    end else begin
                        r_known[r_kidx] <= 1'b1;
                        if (acq_ok) begin
                            r_pend.kind <= KIND_GRANTED;
                            if (acq_excl) begin
                                r_excl[r_kidx] <= r_txn;
                            end else begin
                                r_shared[r_kidx] <= r_shared[r_kidx] | tmask;
                            end
                            r_held[tidx] <= r_held[tidx] | kmask;
                        end else if (r_wcnt[r_kidx] >= CW'(QUEUE_DEPTH)) begin
                            r_pend.kind <= KIND_QUEUE_FULL;
                        end else begin
                            r_pend.kind    <= KIND_QUEUED;
                            r_wcnt[r_kidx] <= r_wcnt[r_kidx] + 1'b1;
                        end
                    end
                end
                ST_RA_STEP: begin
                    if (32'(r_kcnt) == NUM_KEYS) begin
                        if (can_emit) begin
                            if (r_pend_valid) begin
                                r_out       <= r_pend;
                                r_out_valid <= 1'b1;
                            end
                            r_held[tidx]   <= r_held[tidx] & ~r_snap;
                            r_pend_valid   <= 1'b1;
                            r_pend.kind    <= KIND_ALL_RELEASE;
                            r_pend.txn_out <= r_txn;
                            r_pend.key_out <= '0;
                            r_pend.last    <= 1'b0;
                            r_state        <= ST_FINISH;
                        end
                    end else begin
                        r_kcnt <= r_kcnt + 1'b1;
                        if (r_snap[ra_k]) begin
                            r_shared[ra_k] <= r_shared[ra_k] & ~tmask;
                            if (r_excl[ra_k] == r_txn) begin
                                r_excl[ra_k] <= '0;
                            end
                            r_kidx    <= ra_k;
                            r_idx     <= '0;
                            r_kept    <= '0;
                            r_stop    <= 1'b0;
                            r_from_ra <= 1'b1;
                            r_state   <= ST_SCAN_RD;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    if (r_idx < r_wcnt[r_kidx]) begin
                        r_state <= ST_SCAN_EV;
                    end else begin
                        r_wcnt[r_kidx] <= r_kept;
                        r_state        <= r_from_ra ? ST_RA_STEP : ST_FINISH;
                    end
                end
                ST_SCAN_EV: begin
                    if (!e_grant) begin
                        r_kept  <= r_kept + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_SCAN_RD;
                    end else if (can_emit) begin
                        if (r_pend_valid) begin
                            r_out       <= r_pend;
                            r_out_valid <= 1'b1;
                        end
                        if (e_excl) begin
                            r_excl[r_kidx] <= e_txn;
                            r_stop         <= 1'b1;
                        end else begin
                            r_shared[r_kidx] <= r_shared[r_kidx]
                                | ((NUM_TXNS)'(1) << TXW'(e_txn));
                        end
                        r_held[TXW'(e_txn)] <= r_held[TXW'(e_txn)] | kmask;
                        r_pend_valid   <= 1'b1;
                        r_pend.kind    <= KIND_WAITER_GRNT;
                        r_pend.txn_out <= e_txn;
                        r_pend.key_out <= KEY_W'(r_kidx);
                        r_pend.last    <= 1'b0;
                        r_idx          <= r_idx + 1'b1;
                        r_state        <= ST_SCAN_RD;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out         <= r_pend;
                        r_out.last    <= 1'b1;
                        r_out_valid   <= 1'b1;
                        r_pend_valid  <= 1'b0;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `SEL_ASSERT_NOW(a_excl_no_shared, i_clk, i_rst_n, r_excl[r_kidx] != '0, r_shared[r_kidx] == '0, "exclusive holder coexists with shared holders")
    `SEL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_wcnt[r_kidx] <= CW'(QUEUE_DEPTH), "wait count exceeds queue depth")
    `SEL_ASSERT_NOW(a_kept_bound, i_clk, i_rst_n, r_state == ST_SCAN_EV, r_kept <= r_idx, "scan compaction overtook the read pointer")
    `SEL_ASSERT_NOW(a_idle_no_pend, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_valid, "pending result left behind at idle")
    `SEL_ASSERT_NEXT(a_finish_last, i_clk, i_rst_n, r_state == ST_FINISH && out_free, r_out_valid && r_out.last, "final result not marked last")
endmodule
`default_nettype wire

// ===== rtl/sel_ram.sv =====
`default_nettype none
module sel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    import sel_pkg::*;

    localparam int NKEYS  = DEF_NUM_KEYS;
    localparam int NTXNS  = DEF_NUM_TXNS;
    localparam int QDEPTH = DEF_QUEUE_DEPTH;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    sel_req_if req_ch ();
    sel_res_if res_ch ();

    shared_exclusive_lock_table_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // Model of the lock table, kept in step with the items the block accepts.
    typedef struct packed {
        logic             excl;
        logic [TXN_W-1:0] txn;
    } t_waiter;

    logic [TXN_W-1:0] lk_excl_owner [NKEYS];
    logic [NTXNS-1:0] lk_sharers [NKEYS];
    logic             lk_named [NKEYS];
    t_waiter          lk_waiters [NKEYS][$];
    logic [NKEYS-1:0] lk_held [NTXNS];

    t_res pending_results [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int errors = 0;
    int quiet_cycles = 0;

    task automatic push_result(input logic [KIND_W-1:0] kind, input logic [TXN_W-1:0] t,
                               input logic [KEY_W-1:0] k);
        t_res r;
        r.kind = kind;
        r.txn_out = t;
        r.key_out = k;
        r.last = 1'b0;
        pending_results = {pending_results, r};
    endtask

    // Walk a key's waiters in order; granted ones leave, an exclusive grant
    // ends the walk.
    task automatic grant_waiters(input int k);
        t_waiter keep [$];
        t_waiter w;
        bit done;
        done = 0;
        for (int i = 0; i < lk_waiters[k].size(); i++) begin
            w = lk_waiters[k][i];
            if (!done && w.excl && lk_excl_owner[k] == '0 && lk_sharers[k] == '0) begin
                lk_excl_owner[k] = w.txn;
                done = 1;
                lk_held[w.txn][k] = 1'b1;
                push_result(KIND_WAITER_GRNT, w.txn, k[KEY_W-1:0]);
            end else if (!done && !w.excl && lk_excl_owner[k] == '0) begin
                lk_sharers[k][w.txn] = 1'b1;
                lk_held[w.txn][k] = 1'b1;
                push_result(KIND_WAITER_GRNT, w.txn, k[KEY_W-1:0]);
            end else begin
                keep = {keep, w};
            end
        end
        lk_waiters[k] = keep;
    endtask

    task automatic drop_owner(input int k, input logic [TXN_W-1:0] t);
        lk_sharers[k][t] = 1'b0;
        if (lk_excl_owner[k] == t) lk_excl_owner[k] = '0;
    endtask

    task automatic predict_lock_item(input logic [MODE_W-1:0] mode,
                                     input logic [TXN_W-1:0] t, input logic [KEY_W-1:0] k);
        logic [NKEYS-1:0] snap;
        bit ok;
        t_waiter w;
        if (t == '0 || int'(t) >= NTXNS) begin
            push_result(KIND_BAD_TXN, t, (mode == MODE_REL_ALL) ? '0 : k);
        end else if (mode == MODE_REL_ALL) begin
            snap = lk_held[t];
            for (int i = 0; i < NKEYS; i++) begin
                if (snap[i]) begin
                    drop_owner(i, t);
                    grant_waiters(i);
                end
            end
            lk_held[t] &= ~snap;
            push_result(KIND_ALL_RELEASE, t, '0);
        end else if (int'(k) >= NKEYS) begin
            push_result(KIND_UNKNOWN_KEY, t, k);
        end else if (mode == MODE_RELEASE) begin
            if (!lk_named[k]) begin
                push_result(KIND_UNKNOWN_KEY, t, k);
            end else begin
                drop_owner(k, t);
                lk_held[t][k] = 1'b0;
                push_result(KIND_RELEASED, t, k);
                grant_waiters(k);
            end
        end else begin
            lk_named[k] = 1'b1;
            if (mode == MODE_EXCL) ok = lk_excl_owner[k] == '0 && lk_sharers[k] == '0;
            else ok = lk_excl_owner[k] == '0;
            if (ok) begin
                if (mode == MODE_EXCL) lk_excl_owner[k] = t;
                else lk_sharers[k][t] = 1'b1;
                lk_held[t][k] = 1'b1;
                push_result(KIND_GRANTED, t, k);
            end else if (lk_waiters[k].size() >= QDEPTH) begin
                push_result(KIND_QUEUE_FULL, t, k);
            end else begin
                w.excl = (mode == MODE_EXCL);
                w.txn = t;
                lk_waiters[k] = {lk_waiters[k], w};
                push_result(KIND_QUEUED, t, k);
            end
        end
        pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    // Sends one item: random idle cycles first, then holds it until accepted.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TXN_W-1:0] t,
                             input logic [KEY_W-1:0] k);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode = mode;
        req_ch.txn = t;
        req_ch.key = k;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_lock_item(mode, t, k);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic [MODE_W-1:0] mode;
        logic [TXN_W-1:0] t;
        logic [KEY_W-1:0] k;
        mode = MODE_W'($urandom_range(3));
        // Bad ids are a small share; a few txns and keys keep contention high.
        t = ($urandom_range(15) == 0) ? TXN_W'($urandom_range(15))
                                      : TXN_W'($urandom_range(1, 5));
        k = ($urandom_range(3) == 0) ? KEY_W'($urandom_range(7)) : KEY_W'($urandom_range(2));
        send_item(mode, t, k);
    endtask

    task automatic test_directed();
        send_item(MODE_RELEASE, 4'd1, 3'd7);     // release of a key never named
        send_item(MODE_SHARED, 4'd0, 3'd0);      // reserved txn id
        send_item(MODE_REL_ALL, 4'd0, 3'd5);     // reserved txn on release all
        send_item(MODE_EXCL, 4'd15, 3'd7);
        send_item(MODE_SHARED, 4'd1, 3'd7);      // shared waits behind exclusive
        send_item(MODE_EXCL, 4'd15, 3'd7);       // repeated request waits
        send_item(MODE_SHARED, 4'd2, 3'd7);
        send_item(MODE_EXCL, 4'd3, 3'd7);
        send_item(MODE_SHARED, 4'd4, 3'd7);      // queue is full, so this is rejected
        send_item(MODE_RELEASE, 4'd15, 3'd7);    // grants shared waiters, skips excl
        send_item(MODE_RELEASE, 4'd9, 3'd7);     // non-holder release rescans
        send_item(MODE_SHARED, 4'd1, 3'd0);
        send_item(MODE_EXCL, 4'd1, 3'd0);        // upgrade waits
        send_item(MODE_SHARED, 4'd1, 3'd1);
        send_item(MODE_EXCL, 4'd2, 3'd1);
        send_item(MODE_REL_ALL, 4'd1, 3'd0);     // walks every held key
        send_item(MODE_REL_ALL, 4'd2, 3'd0);
        send_item(MODE_REL_ALL, 4'd14, 3'd0);    // holds nothing
        wait_drained();
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (n) send_random_item();
        wait_drained();
    endtask

    // The receiver holds off long enough that the block backs up into the
    // request side, then the sender waits for every expected result.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 300;
        repeat (12) send_random_item();
        wait_drained();
    endtask

    // Receiver: random stalls plus one long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Checks each accepted result against the oldest expected one.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d txn=%0d key=%0d",
                       res_ch.kind, res_ch.txn_out, res_ch.key_out);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_ch.kind !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, res_ch.kind);
                    errors++;
                end
                if (res_ch.txn_out !== exp_r.txn_out) begin
                    $error("txn_out: expected %0d, got %0d", exp_r.txn_out, res_ch.txn_out);
                    errors++;
                end
                if (res_ch.key_out !== exp_r.key_out) begin
                    $error("key_out: expected %0d, got %0d", exp_r.key_out, res_ch.key_out);
                    errors++;
                end
                if (res_ch.last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_SHARED;
        req_ch.txn = '0;
        req_ch.key = '0;
        res_ch.ready = 1'b0;
        for (int i = 0; i < NKEYS; i++) begin
            lk_excl_owner[i] = '0;
            lk_sharers[i] = '0;
            lk_named[i] = 1'b0;
        end
        for (int i = 0; i < NTXNS; i++) lk_held[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(45, 0, 0);
        test_random_phase(45, 47, 0);
        test_random_phase(45, 0, 47);
        test_random_phase(45, 18, 18);
        test_backpressure();
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/sel_pkg.sv
rtl/sel_req_if.sv
rtl/sel_res_if.sv
rtl/sel_ram.sv
rtl/shared_exclusive_lock_table_unit.sv
dv/tb.sv
